[src/tea_pkg.sv]
package tea_pkg;

  // Round constant and round count of the cipher
  localparam logic [31:0] TEA_DELTA  = 32'h9e37_79b9;
  localparam int          TEA_ROUNDS = 32;
  // One cell per half-round
  localparam int          NUM_CELLS  = 2 * TEA_ROUNDS;

  // Operation codes carried by the op field
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Register map, word index taken from paddr[3:2]
  localparam int          ADDR_W = 4;
  localparam logic [1:0]  REG_KEY0 = 2'd0;
  localparam logic [1:0]  REG_KEY1 = 2'd1;
  localparam logic [1:0]  REG_KEY2 = 2'd2;
  localparam logic [1:0]  REG_KEY3 = 2'd3;

  // 128-bit key as four words
  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  // Payload travelling down the chain of cells
  typedef struct packed {
    logic        op;
    logic [31:0] y;
    logic [31:0] z;
  } stage_t;

endpackage

[src/tea_if.sv]
interface tea_blk_if;
  import tea_pkg::*;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] word0;
  logic [31:0] word1;

  modport source (output valid, output op, output word0, output word1, input ready);
  modport sink   (input valid, input op, input word0, input word1, output ready);
endinterface

interface tea_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word0;
  logic [31:0] out_word1;

  modport source (output valid, output out_word0, output out_word1, input ready);
  modport sink   (input valid, input out_word0, input out_word1, output ready);
endinterface

[src/tea_key_regs.sv]
module tea_key_regs
  import tea_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output key_t              key
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Write a key word in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KEY0: key.k0 <= pwdata;
        REG_KEY1: key.k1 <= pwdata;
        REG_KEY2: key.k2 <= pwdata;
        REG_KEY3: key.k3 <= pwdata;
        default:  key    <= key;
      endcase
    end
  end

  // Read back the selected word
  always_comb begin
    unique case (reg_sel)
      REG_KEY0: prdata = key.k0;
      REG_KEY1: prdata = key.k1;
      REG_KEY2: prdata = key.k2;
      REG_KEY3: prdata = key.k3;
      default:  prdata = '0;
    endcase
  end

endmodule

[src/tea_cell.sv]
module tea_cell
  import tea_pkg::*;
#(
  parameter int ROUND_IDX = 0,
  parameter bit HALF      = 1'b0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  key_t   key,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   out_valid,
  output stage_t out_data
);

  // Running sum of this round, fixed at elaboration for both directions
  localparam logic [31:0] SUM_ENC = 32'(TEA_DELTA * 32'(ROUND_IDX + 1));
  localparam logic [31:0] SUM_DEC = 32'(TEA_DELTA * 32'(TEA_ROUNDS - ROUND_IDX));

  logic        upd_y;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] sum;
  logic [31:0] mix;
  logic [31:0] res;
  stage_t      data_next;

  // Encryption updates y first, decryption z first
  assign upd_y = (in_data.op == HALF);
  assign src   = upd_y ? in_data.z : in_data.y;
  assign dst   = upd_y ? in_data.y : in_data.z;
  assign ka    = upd_y ? key.k0 : key.k2;
  assign kb    = upd_y ? key.k1 : key.k3;
  assign sum   = (in_data.op == OP_DECRYPT) ? SUM_DEC : SUM_ENC;

  // Half-round mix, added or taken away
  assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
  assign res = (in_data.op == OP_DECRYPT) ? (dst - mix) : (dst + mix);

  always_comb begin
    data_next = in_data;
    if (upd_y) begin
      data_next.y = res;
    end else begin
      data_next.z = res;
    end
  end

  // Advance with the whole chain, hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= data_next;
    end
  end

endmodule

[src/tea_block_cipher.sv]
// Channel  Dir   Payload                 Beat when
// blk      sink  op, word0, word1        blk.valid && blk.ready
// res      src   out_word0, out_word1    res.valid && res.ready
// apb      sink  key_word0..key_word3    psel && penable && pwrite
//
// One block per cycle unless the chain stalls; each block passes through one
// register per half-round cell, the last one serving as the output register.
// The whole chain advances together; it holds only while a result waits and
// res.ready is low, so blk.ready = !res.valid || res.ready.
// Synchronous reset empties the chain and clears the key to zero.
module tea_block_cipher
  import tea_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tea_blk_if.sink           blk,
  tea_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  key_t                 key;
  logic                 adv;
  logic [NUM_CELLS:0]   vld;
  stage_t               data [NUM_CELLS+1];

  tea_key_regs u_key_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  // Stall the chain only when a result waits untaken
  assign adv       = !vld[NUM_CELLS] || res.ready;
  assign blk.ready = adv;

  // Feed the head of the chain
  assign vld[0]       = blk.valid;
  assign data[0].op   = blk.op;
  assign data[0].y    = blk.word0;
  assign data[0].z    = blk.word1;

  // One cell per half-round
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tea_cell #(
      .ROUND_IDX (i / 2),
      .HALF      (1'(i % 2))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .key       (key),
      .in_valid  (vld[i]),
      .in_data   (data[i]),
      .out_valid (vld[i+1]),
      .out_data  (data[i+1])
    );
  end

  assign res.valid     = vld[NUM_CELLS];
  assign res.out_word0 = data[NUM_CELLS].y;
  assign res.out_word1 = data[NUM_CELLS].z;

  // Chain empty after reset
  a_empty_after_rst: assert property (@(posedge clk)
    rst |=> (vld[NUM_CELLS:1] == '0))
    else $error("chain not empty after reset");

  // Valid bits shift by one cell on each advance
  a_shift: assert property (@(posedge clk) disable iff (rst)
    adv |=> (vld[NUM_CELLS:2] == $past(vld[NUM_CELLS-1:1])))
    else $error("valid bits did not shift with the chain");

  // Valid bits hold while the chain is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld[NUM_CELLS:1]))
    else $error("valid bits moved during a stall");

  // An accepted beat lands in the first cell
  a_load: assert property (@(posedge clk) disable iff (rst)
    (blk.valid && blk.ready) |=> vld[1])
    else $error("accepted beat lost at chain head");

endmodule
